/* src/nlpa_pkg.sv */
// ----------------------------------------------------------------------------
// nlpa_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package nlpa_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int ACCUM_BITS      = 32;
	localparam int COUNT_BITS      = 32;
	localparam int LSIZE_BITS      = 3;
	localparam logic [LSIZE_BITS-1:0] LSIZE_RESET = 3'd4;
	localparam logic [LSIZE_BITS-1:0] LSIZE_MIN   = 3'd1;
	localparam logic [LSIZE_BITS-1:0] LSIZE_MAX   = 3'd4;
	localparam logic [31:0] START_WORD = 32'h0100_0000;
	localparam logic [1:0]  SC_LAST_IDX = 2'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_TRUNC    = 2'd2
	} status_t;

	// work produced by one input byte, drained by the emitter
	typedef struct packed {
		logic                  sc;     // four start code bytes
		logic                  data;   // one payload byte
		logic                  close;  // sample closing result
		logic [7:0]            byte_v;
		status_t               status;
		logic [COUNT_BITS-1:0] bw;
	} desc_t;

endpackage

/* src/nlpa_ifs.sv */
// ----------------------------------------------------------------------------
// nlpa interfaces
// Valid/ready channels for sample bytes, output bytes and the config write.
// ----------------------------------------------------------------------------
interface nlpa_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [31:0] sample_length;
	logic        sample_end;

	modport source (output valid, data_byte, sample_length, sample_end, input ready);
	modport sink   (input valid, data_byte, sample_length, sample_end, output ready);
endinterface

interface nlpa_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_start_code;
	logic        run_last;
	logic        sample_done;
	logic [1:0]  status;
	logic [31:0] bytes_written;

	modport source (output valid, out_byte, is_start_code, run_last, sample_done, status,
		bytes_written, input ready);
	modport sink   (input valid, out_byte, is_start_code, run_last, sample_done, status,
		bytes_written, output ready);
endinterface

interface nlpa_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] length_size;

	modport source (output valid, length_size, input ready);
	modport sink   (input valid, length_size, output ready);
endinterface

/* src/nlpa_parse.sv */
// ----------------------------------------------------------------------------
// nlpa_parse
// Input register, parser state and per-byte work descriptor.
// ----------------------------------------------------------------------------
module nlpa_parse
	import nlpa_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nlpa_in_if.sink               sample_in,
	input  logic [LSIZE_BITS-1:0] length_size,
	output logic                  desc_valid,
	input  logic                  desc_ready,
	output desc_t                 desc
);

	localparam logic [ACCUM_BITS-1:0] LIMIT = {ACCUM_BITS{1'b1}} >> (ACCUM_BITS - LENGTH_BITS);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic [31:0]            slen_s1;
	logic                   end_s1;

	logic                   in_payload_q, n_in_payload;
	logic [ACCUM_BITS-1:0]  accum_q, n_accum;
	logic [2:0]             seen_q, n_seen;
	logic [LENGTH_BITS-1:0] left_q, n_left;
	logic                   drop_q, n_drop;
	logic [COUNT_BITS-1:0]  wc_q, n_wc;

	logic [LSIZE_BITS-1:0]  lsize;
	logic [ACCUM_BITS-1:0]  shifted;
	logic [2:0]             seen_inc;
	logic [2:0]             add;
	logic [COUNT_BITS:0]    wc_sum;
	logic [COUNT_BITS-1:0]  wc_sat;
	logic                   trunc;
	logic                   has_res;
	logic                   advance;

	assign has_res    = desc.sc | desc.data | desc.close;
	assign desc_valid = valid_s1 & has_res;
	assign advance    = valid_s1 & (~has_res | desc_ready);
	assign sample_in.ready = ~valid_s1 | advance;

	always_comb begin
		if (length_size < LSIZE_MIN)
			lsize = LSIZE_MIN;
		else if (length_size > LSIZE_MAX)
			lsize = LSIZE_MAX;
		else
			lsize = length_size;
	end

	always_comb begin
		n_in_payload = in_payload_q;
		n_accum      = accum_q;
		n_seen       = seen_q;
		n_left       = left_q;
		n_drop       = drop_q;
		trunc        = 1'b0;
		add          = 3'd0;
		desc         = '0;
		shifted      = {accum_q[ACCUM_BITS-9:0], byte_s1};
		seen_inc     = seen_q + 3'd1;
		if (drop_q) begin
		end else if (in_payload_q) begin
			desc.data   = 1'b1;
			desc.byte_v = byte_s1;
			add         = 3'd1;
			n_left      = left_q - LENGTH_BITS'(1);
			if (left_q == LENGTH_BITS'(1))
				n_in_payload = 1'b0;
		end else if (seen_inc >= lsize) begin
			n_accum = '0;
			n_seen  = '0;
			if (shifted == '0) begin
			end else if (shifted > LIMIT || shifted > slen_s1) begin
				n_drop = 1'b1;
			end else if (end_s1) begin
				trunc = 1'b1;
			end else begin
				desc.sc      = 1'b1;
				add          = 3'd4;
				n_in_payload = 1'b1;
				n_left       = shifted[LENGTH_BITS-1:0];
			end
		end else begin
			n_accum = shifted;
			n_seen  = seen_inc;
		end

		wc_sum = {1'b0, wc_q} + (COUNT_BITS+1)'(add);
		wc_sat = wc_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : wc_sum[COUNT_BITS-1:0];
		n_wc   = wc_sat;

		if (end_s1) begin
			desc.close = 1'b1;
			desc.bw    = wc_sat;
			if (n_drop)
				desc.status = ST_TOO_LONG;
			else if (trunc || n_in_payload || n_seen != 3'd0)
				desc.status = ST_TRUNC;
			else
				desc.status = ST_OK;
			n_in_payload = 1'b0;
			n_accum      = '0;
			n_seen       = '0;
			n_left       = '0;
			n_drop       = 1'b0;
			n_wc         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			byte_s1 <= sample_in.data_byte;
			slen_s1 <= sample_in.sample_length;
			end_s1  <= sample_in.sample_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			accum_q      <= '0;
			seen_q       <= '0;
			left_q       <= '0;
			drop_q       <= 1'b0;
			wc_q         <= '0;
		end else if (advance) begin
			in_payload_q <= n_in_payload;
			accum_q      <= n_accum;
			seen_q       <= n_seen;
			left_q       <= n_left;
			drop_q       <= n_drop;
			wc_q         <= n_wc;
		end
	end

endmodule

/* src/nlpa_emit.sv */
// ----------------------------------------------------------------------------
// nlpa_emit
// Result register: holds one descriptor and sends its results one per cycle while nal_out.ready is high.
// ----------------------------------------------------------------------------
module nlpa_emit
	import nlpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      desc_valid,
	output logic      desc_ready,
	input  desc_t     desc,
	nlpa_out_if.source nal_out
);

	logic       valid_s2;
	desc_t      desc_s2;
	logic [1:0] idx_q;
	logic       last;
	logic       is_close;
	logic       xfer;

	always_comb begin
		if (desc_s2.sc)
			last = (idx_q == SC_LAST_IDX);
		else if (desc_s2.data && desc_s2.close)
			last = (idx_q == 2'd1);
		else
			last = 1'b1;
		is_close = desc_s2.close & ~desc_s2.sc & ~(desc_s2.data & (idx_q == 2'd0));
	end

	assign xfer       = nal_out.valid & nal_out.ready;
	assign desc_ready = ~valid_s2 | (xfer & last);

	assign nal_out.valid         = valid_s2;
	assign nal_out.is_start_code = desc_s2.sc;
	assign nal_out.run_last      = last;
	assign nal_out.sample_done   = is_close;
	assign nal_out.status        = is_close ? desc_s2.status : ST_OK;
	assign nal_out.bytes_written = is_close ? desc_s2.bw : '0;
	assign nal_out.out_byte      = desc_s2.sc ? START_WORD[8*idx_q +: 8] :
		(is_close ? 8'h00 : desc_s2.byte_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (desc_ready) begin
			valid_s2 <= desc_valid;
			idx_q    <= '0;
		end else if (xfer) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid)
			desc_s2 <= desc;
	end

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		nal_out.valid && nal_out.sample_done |-> nal_out.run_last)
		else $error("sample_done without run_last");
	a_sc_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		nal_out.valid |-> !(nal_out.is_start_code && nal_out.sample_done))
		else $error("start code byte marked as sample close");
	a_status_only_close: assert property (@(posedge clk) disable iff (!arst_n)
		nal_out.valid && !nal_out.sample_done |-> nal_out.status == ST_OK &&
		nal_out.bytes_written == '0)
		else $error("status or count on a data result");
	a_sc_advance: assert property (@(posedge clk) disable iff (!arst_n)
		nal_out.valid && nal_out.ready && nal_out.is_start_code && !nal_out.run_last
		|=> nal_out.valid && nal_out.is_start_code)
		else $error("start code run broken");
`endif

endmodule

/* src/nal_length_prefix_to_annexb.sv */
// ----------------------------------------------------------------------------
// nal_length_prefix_to_annexb
// Converts length-prefixed NAL units to start-code delimited byte stream.
// ----------------------------------------------------------------------------
//  channel     dir  handshake      payload
//  sample_in   in   valid/ready    data_byte, sample_length, sample_end
//  nal_out     out  valid/ready    out_byte, is_start_code, run_last,
//                                  sample_done, status, bytes_written
//  cfg         in   valid/ready    length_size (ready always high)
//
// One result per cycle while nal_out.ready is high; a payload byte gives one
// result, a byte that opens a unit four (start code) and a payload byte that
// ends the sample two. Bytes pass the input register, then the result register.
// Reset clears the parser state and sets length_size to 4.
// Output stalls back up through the result register to sample_in.ready.
// ----------------------------------------------------------------------------
module nal_length_prefix_to_annexb
	import nlpa_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nlpa_in_if.sink    sample_in,
	nlpa_out_if.source nal_out,
	nlpa_cfg_if.sink   cfg
);

	logic [LSIZE_BITS-1:0] lsize_q;
	logic                  desc_valid;
	logic                  desc_ready;
	desc_t                 desc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsize_q <= LSIZE_RESET;
		end else if (cfg.valid) begin
			lsize_q <= cfg.length_size;
		end
	end

	nlpa_parse #(.LENGTH_BITS(LENGTH_BITS)) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_in   (sample_in),
		.length_size (lsize_q),
		.desc_valid  (desc_valid),
		.desc_ready  (desc_ready),
		.desc        (desc)
	);

	nlpa_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc       (desc),
		.nal_out    (nal_out)
	);

endmodule
